[sv/assert_macros.svh]
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[sv/wmv_pkg.sv]
package wmv_pkg;

    localparam int MAX_ITEMS_DEF   = 1024;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int SAMPLE_W    = 32;
    localparam int WEIGHT_IN_W = 16;
    localparam int CFG_W       = 26;
    localparam int STATUS_W    = 2;
    localparam int MEAN_W      = 32;
    localparam int VAR_W       = 64;
    localparam int WSUM_W      = 64;
    localparam int QUOT_W      = 64;

    localparam logic [CFG_W-1:0] MIN_WSUM_RESET = 26'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_LOW_WEIGHT = 2'd1,
        ST_OVERFLOW   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHECK,
        B_MDIV,
        B_PASS,
        B_VDIV,
        B_EMIT
    } t_bstate;

endpackage

[sv/wmv_in_if.sv]
interface wmv_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [wmv_pkg::SAMPLE_W-1:0] sample;
    logic [wmv_pkg::WEIGHT_IN_W-1:0]     weight;
    logic                                last;

    modport source (output valid, output sample, output weight, output last, input ready);
    modport sink   (input valid, input sample, input weight, input last, output ready);
endinterface

[sv/wmv_out_if.sv]
interface wmv_out_if;
    logic                          valid;
    logic                          ready;
    logic [wmv_pkg::STATUS_W-1:0]  status;
    logic signed [wmv_pkg::MEAN_W-1:0] mean;
    logic [wmv_pkg::VAR_W-1:0]     variance;

    modport source (output valid, output status, output mean, output variance, input ready);
    modport sink   (input valid, input status, input mean, input variance, output ready);
endinterface

[sv/wmv_cfg_if.sv]
interface wmv_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [wmv_pkg::CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/wmv_ram.sv]
module wmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[sv/wmv_front.sv]
module wmv_front #(
    parameter int MAX_ITEMS   = wmv_pkg::MAX_ITEMS_DEF,
    parameter int WEIGHT_BITS = wmv_pkg::WEIGHT_BITS_DEF,
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1),
    localparam int ADDR_W = $clog2(MAX_ITEMS),
    localparam int WT_W   = WEIGHT_BITS + CNT_W,
    localparam int ENT_W  = wmv_pkg::SAMPLE_W + WEIGHT_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    wmv_in_if.sink                     i_in,
    input  logic                       i_done,
    output logic                       o_wr_en,
    output logic [ADDR_W-1:0]          o_wr_addr,
    output logic [ENT_W-1:0]           o_wr_data,
    output logic                       o_push,
    output logic [CNT_W-1:0]           o_job_cnt,
    output logic [WT_W-1:0]            o_job_wt,
    output logic [wmv_pkg::WSUM_W-1:0] o_job_wsum,
    output logic                       o_job_ovf
);
    localparam int PROD_W = wmv_pkg::SAMPLE_W + WEIGHT_BITS + 1;
    localparam int WSUM_W = wmv_pkg::WSUM_W;

    logic                       r_busy;
    logic [CNT_W-1:0]           r_cnt;
    logic [WT_W-1:0]            r_wt;
    logic [WSUM_W-1:0]          r_wsum;
    logic [WSUM_W-1:0]          n_wsum;
    logic                       r_ovf;
    logic                       r_p_vld;
    logic                       r_p_last;
    logic signed [PROD_W-1:0]   r_prod;

    logic                             accept;
    logic                             room;
    logic                             store;
    logic [WEIGHT_BITS+wmv_pkg::WEIGHT_IN_W-1:0] w_ext;
    logic [WEIGHT_BITS-1:0]           w;
    logic signed [PROD_W-1:0]         prod;

    assign i_in.ready = !r_busy;
    assign accept     = i_in.valid && !r_busy;
    assign room       = r_cnt < CNT_W'(MAX_ITEMS);
    assign store      = accept && room;
    assign w_ext      = {{WEIGHT_BITS{1'b0}}, i_in.weight};
    assign w          = w_ext[WEIGHT_BITS-1:0];
    assign prod       = PROD_W'(i_in.sample) * $signed({1'b0, w});

    assign o_wr_en   = store;
    assign o_wr_addr = r_cnt[ADDR_W-1:0];
    assign o_wr_data = {i_in.sample, w};

    always_comb begin
        n_wsum = r_wsum;
        if (r_p_vld) begin
            n_wsum = r_wsum + {{(WSUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    assign o_push     = r_p_last;
    assign o_job_cnt  = r_cnt;
    assign o_job_wt   = r_wt;
    assign o_job_wsum = n_wsum;
    assign o_job_ovf  = r_ovf;

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_wt     <= '0;
            r_wsum   <= '0;
            r_ovf    <= 1'b0;
            r_p_vld  <= 1'b0;
            r_p_last <= 1'b0;
        end else begin
            r_p_vld  <= store;
            r_p_last <= accept && i_in.last;
            if (accept && i_in.last) begin
                r_busy <= 1'b1;
            end else if (i_done) begin
                r_busy <= 1'b0;
            end
            if (r_p_last) begin
                r_cnt  <= '0;
                r_wt   <= '0;
                r_wsum <= '0;
                r_ovf  <= 1'b0;
            end else begin
                r_wsum <= n_wsum;
                if (store) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_wt  <= r_wt + WT_W'(w);
                end
                if (accept && !room) begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end
endmodule

[sv/wmv_jobq.sv]
module wmv_jobq #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_data [2];
    logic             r_rd;
    logic             r_wr;
    logic [1:0]       r_cnt;

    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_data[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

[sv/wmv_div.sv]
module wmv_div #(
    parameter int DEN_W = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DEN_W-1:0]           i_hi,
    input  logic [wmv_pkg::QUOT_W-1:0] i_lo,
    input  logic [DEN_W-1:0]           i_den,
    output logic                       o_done,
    output logic [wmv_pkg::QUOT_W-1:0] o_quot
);
    localparam int QW    = wmv_pkg::QUOT_W;
    localparam int IDX_W = $clog2(QW);

    logic             r_busy;
    logic             r_done;
    logic [IDX_W-1:0] r_idx;
    logic [DEN_W-1:0] r_rem;
    logic [QW-1:0]    r_lo;
    logic [QW-1:0]    r_q;

    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign sh   = {r_rem, r_lo[QW-1]};
    assign ge   = sh >= {1'b0, i_den};
    assign diff = sh - {1'b0, i_den};

    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_hi >= i_den) begin
                    r_q    <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= i_hi;
                    r_lo   <= i_lo;
                    r_idx  <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
                r_lo  <= {r_lo[QW-2:0], 1'b0};
                r_q   <= {r_q[QW-2:0], ge};
                r_idx <= r_idx + 1'b1;
                if (r_idx == IDX_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

[sv/wmv_back.sv]
module wmv_back #(
    parameter int MAX_ITEMS   = wmv_pkg::MAX_ITEMS_DEF,
    parameter int WEIGHT_BITS = wmv_pkg::WEIGHT_BITS_DEF,
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1),
    localparam int ADDR_W = $clog2(MAX_ITEMS),
    localparam int WT_W   = WEIGHT_BITS + CNT_W,
    localparam int ENT_W  = wmv_pkg::SAMPLE_W + WEIGHT_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [wmv_pkg::CFG_W-1:0]  i_min_wsum,
    input  logic                       i_job_valid,
    input  logic [CNT_W-1:0]           i_job_cnt,
    input  logic [WT_W-1:0]            i_job_wt,
    input  logic [wmv_pkg::WSUM_W-1:0] i_job_wsum,
    input  logic                       i_job_ovf,
    output logic                       o_pop,
    output logic                       o_rd_en,
    output logic [ADDR_W-1:0]          o_rd_addr,
    input  logic [ENT_W-1:0]           i_rd_data,
    output logic                       o_done,
    wmv_out_if.source                  o_out
);
    localparam int SW     = wmv_pkg::SAMPLE_W;
    localparam int QW     = wmv_pkg::QUOT_W;
    localparam int ACC_W  = QW + WT_W;
    localparam int PW     = 32 + WEIGHT_BITS;
    localparam int CMP_W  = (WT_W > wmv_pkg::CFG_W) ? WT_W : wmv_pkg::CFG_W;

    wmv_pkg::t_bstate r_state;
    wmv_pkg::t_bstate n_state;

    logic [CNT_W-1:0]          r_cnt;
    logic [WT_W-1:0]           r_wt;
    logic [wmv_pkg::WSUM_W-1:0] r_wsum;
    logic                      r_ovf;

    wmv_pkg::t_status          r_status;
    logic [wmv_pkg::MEAN_W-1:0] r_mean;
    logic signed [SW+1:0]      r_m;
    logic [wmv_pkg::VAR_W-1:0] r_var;

    logic [CNT_W-1:0]          r_iss;
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic                      r_v4;
    logic [31:0]               r_ad;
    logic [WEIGHT_BITS-1:0]    r_w2;
    logic [63:0]               r_sq;
    logic [WEIGHT_BITS-1:0]    r_w3;
    logic [PW-1:0]             r_plo;
    logic [PW-1:0]             r_phi;
    logic [ACC_W-1:0]          r_acc;

    logic                      r_out_vld;
    wmv_pkg::t_status          r_o_status;
    logic [wmv_pkg::MEAN_W-1:0] r_o_mean;
    logic [wmv_pkg::VAR_W-1:0] r_o_var;

    logic                      low;
    logic                      pass_done;
    logic                      out_free;
    logic                      div_start;
    logic                      div_done;
    logic [WT_W-1:0]           div_hi;
    logic [QW-1:0]             div_lo;
    logic [QW-1:0]             quot;
    logic [wmv_pkg::WSUM_W-1:0] mag;
    logic                      neg;
    logic [SW:0]               qs;
    logic signed [SW+1:0]      d;
    logic [SW+1:0]             ad;
    logic signed [SW-1:0]      rx;

    assign low = (r_wt == '0) || (CMP_W'(r_wt) < CMP_W'(i_min_wsum));
    assign neg = r_wsum[wmv_pkg::WSUM_W-1];
    assign mag = neg ? (~r_wsum + 1'b1) : r_wsum;
    assign pass_done = (r_iss == r_cnt) && !(r_v1 || r_v2 || r_v3 || r_v4);
    assign out_free  = !r_out_vld || o_out.ready;

    assign div_hi = (r_state == wmv_pkg::B_PASS) ? r_acc[ACC_W-1:QW] : '0;
    assign div_lo = (r_state == wmv_pkg::B_PASS) ? r_acc[QW-1:0] : mag;

    always_comb begin
        if (neg) begin
            qs = (quot > QW'(33'h080000000)) ? 33'h080000000 : quot[SW:0];
        end else begin
            qs = (quot > QW'(33'h07FFFFFFF)) ? 33'h07FFFFFFF : quot[SW:0];
        end
    end

    assign rx = i_rd_data[ENT_W-1:WEIGHT_BITS];
    assign d  = (SW+2)'(rx) - r_m;
    assign ad = d[SW+1] ? (~d + 1'b1) : d;

    wmv_div #(.DEN_W(WT_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_hi    (div_hi),
        .i_lo    (div_lo),
        .i_den   (r_wt),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            wmv_pkg::B_IDLE:  if (i_job_valid) n_state = wmv_pkg::B_CHECK;
            wmv_pkg::B_CHECK: n_state = low ? wmv_pkg::B_EMIT : wmv_pkg::B_MDIV;
            wmv_pkg::B_MDIV:  if (div_done) n_state = wmv_pkg::B_PASS;
            wmv_pkg::B_PASS:  if (pass_done) n_state = wmv_pkg::B_VDIV;
            wmv_pkg::B_VDIV:  if (div_done) n_state = wmv_pkg::B_EMIT;
            wmv_pkg::B_EMIT:  if (out_free) n_state = wmv_pkg::B_IDLE;
            default:          n_state = wmv_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        div_start = 1'b0;
        o_done    = 1'b0;
        o_rd_en   = 1'b0;
        case (r_state)
            wmv_pkg::B_IDLE:  o_pop = i_job_valid;
            wmv_pkg::B_CHECK: div_start = !low;
            wmv_pkg::B_PASS: begin
                div_start = pass_done;
                o_rd_en   = r_iss != r_cnt;
            end
            wmv_pkg::B_EMIT:  o_done = out_free;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign o_rd_addr = r_iss[ADDR_W-1:0];

    // variance pipeline datapath
    always_ff @(posedge i_clk) begin
        r_ad  <= ad[31:0];
        r_w2  <= i_rd_data[WEIGHT_BITS-1:0];
        r_sq  <= r_ad * r_ad;
        r_w3  <= r_w2;
        r_plo <= r_sq[31:0] * r_w3;
        r_phi <= r_sq[63:32] * r_w3;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cnt  <= i_job_cnt;
            r_wt   <= i_job_wt;
            r_wsum <= i_job_wsum;
            r_ovf  <= i_job_ovf;
            r_acc  <= '0;
        end else if (r_v4) begin
            r_acc <= r_acc + ACC_W'(r_plo) + (ACC_W'(r_phi) << 32);
        end
        if (r_state == wmv_pkg::B_CHECK && low) begin
            r_status <= wmv_pkg::ST_LOW_WEIGHT;
            r_mean   <= '0;
            r_var    <= '0;
        end
        if (r_state == wmv_pkg::B_MDIV && div_done) begin
            r_mean <= neg ? (~qs[SW-1:0] + 1'b1) : qs[SW-1:0];
            r_m    <= neg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
        end
        if (r_state == wmv_pkg::B_VDIV && div_done) begin
            r_var    <= quot;
            r_status <= r_ovf ? wmv_pkg::ST_OVERFLOW : wmv_pkg::ST_OK;
        end
        if (o_done) begin
            r_o_status <= r_status;
            r_o_mean   <= r_mean;
            r_o_var    <= r_var;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wmv_pkg::B_IDLE;
            r_iss     <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_iss <= '0;
            end else if (o_rd_en) begin
                r_iss <= r_iss + 1'b1;
            end
            r_v1 <= o_rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (o_done) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.status   = r_o_status;
    assign o_out.mean     = r_o_mean;
    assign o_out.variance = r_o_var;
endmodule

[sv/weighted_mean_variance_core.sv]
// load phase: one pair beat per cycle while ready is high; pairs that fit are stored and
// summed, later ones only flag overflow; after the last beat: mean divide, variance pass
// over the stored pairs (one store read per cycle), variance divide, then the result beat
// input ready is low from the last beat until its result enters the output register
// reset (synchronous, active low) clears sums, counters, queue and control; the store
// is not cleared and min_weight_sum returns to 1
`include "assert_macros.svh"

module weighted_mean_variance_core #(
    parameter int MAX_ITEMS   = wmv_pkg::MAX_ITEMS_DEF,
    parameter int WEIGHT_BITS = wmv_pkg::WEIGHT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wmv_in_if.sink    i_in,
    wmv_out_if.source o_out,
    wmv_cfg_if.sink   i_cfg
);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int WT_W   = WEIGHT_BITS + CNT_W;
    localparam int ENT_W  = wmv_pkg::SAMPLE_W + WEIGHT_BITS;
    localparam int WSUM_W = wmv_pkg::WSUM_W;
    localparam int JOB_W  = CNT_W + WT_W + WSUM_W + 1;

    logic [wmv_pkg::CFG_W-1:0] r_min_wsum;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ENT_W-1:0]  rd_data;

    logic              push;
    logic [CNT_W-1:0]  f_cnt;
    logic [WT_W-1:0]   f_wt;
    logic [WSUM_W-1:0] f_wsum;
    logic              f_ovf;
    logic              pop;
    logic              q_valid;
    logic [JOB_W-1:0]  q_data;
    logic              done;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_wsum <= wmv_pkg::MIN_WSUM_RESET;
        end else if (i_cfg.valid) begin
            r_min_wsum <= i_cfg.data;
        end
    end

    wmv_front #(.MAX_ITEMS(MAX_ITEMS), .WEIGHT_BITS(WEIGHT_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_done     (done),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_push     (push),
        .o_job_cnt  (f_cnt),
        .o_job_wt   (f_wt),
        .o_job_wsum (f_wsum),
        .o_job_ovf  (f_ovf)
    );

    wmv_jobq #(.WIDTH(JOB_W)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cnt, f_wt, f_wsum, f_ovf}),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    wmv_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ITEMS)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    wmv_back #(.MAX_ITEMS(MAX_ITEMS), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_min_wsum  (r_min_wsum),
        .i_job_valid (q_valid),
        .i_job_cnt   (q_data[JOB_W-1 -: CNT_W]),
        .i_job_wt    (q_data[WSUM_W+WT_W:WSUM_W+1]),
        .i_job_wsum  (q_data[WSUM_W:1]),
        .i_job_ovf   (q_data[0]),
        .o_pop       (pop),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_done      (done),
        .o_out       (o_out)
    );

    `ASSERT_PROP(a_busy_blocks_in, i_clk, i_rst_n, q_valid |-> !i_in.ready, "beat taken while a set is pending")
    `ASSERT_NEVER(a_queue_no_overrun, i_clk, i_rst_n, push && q_valid, "job pushed onto a pending job")
    `ASSERT_PROP(a_low_weight_zero, i_clk, i_rst_n, (o_out.valid && o_out.status == wmv_pkg::ST_LOW_WEIGHT) |-> (o_out.mean == '0 && o_out.variance == '0), "low weight result carries data")
    `ASSERT_NEVER(a_store_idle_in_back, i_clk, i_rst_n, wr_en && rd_en, "store written during variance pass")
endmodule

[dv/wmv_checker.sv]
`timescale 1ns / 1ps

module wmv_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wmv_in_if.sink    i_in,
    wmv_out_if.sink   i_out,
    wmv_cfg_if.sink   i_cfg,
    output int        o_errors,
    output int        o_pending,
    output int        o_results
);
    localparam int DEPTH = wmv_pkg::MAX_ITEMS_DEF;

    typedef struct packed {
        wmv_pkg::t_status           status;
        logic [wmv_pkg::MEAN_W-1:0] mean;
        logic [wmv_pkg::VAR_W-1:0]  variance;
    } t_stats;

    logic signed [31:0]          sample_mem [DEPTH];
    logic [15:0]                 weight_mem [DEPTH];
    int                          pair_count;
    logic [63:0]                 wsum;
    logic [63:0]                 xsum;
    logic                        dropped;
    logic [wmv_pkg::CFG_W-1:0]   min_wsum;
    t_stats                      stats_q[$];

    function automatic logic [63:0] div_sat(logic [127:0] num, logic [63:0] den);
        logic [127:0] q;
        q = num / den;
        return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
    endfunction

    function automatic logic signed [63:0] sample_sext(int i);
        return 64'(sample_mem[i]);
    endfunction

    function automatic t_stats finish_set();
        t_stats           r;
        logic [63:0]      mag;
        logic [63:0]      q;
        logic signed [63:0] m;
        logic signed [63:0] d;
        logic [63:0]      ad;
        logic [127:0]     acc;
        r = '0;
        if (wsum == 0 || wsum < {38'd0, min_wsum}) begin
            r.status = wmv_pkg::ST_LOW_WEIGHT;
            return r;
        end
        mag = xsum[63] ? -xsum : xsum;
        q = mag / wsum;
        if (xsum[63]) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            m = -$signed(q);
        end else begin
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            m = $signed(q);
        end
        r.mean = m[31:0];
        acc = '0;
        for (int i = 0; i < pair_count; i++) begin
            d = sample_sext(i) - m;
            ad = d < 0 ? -d : d;
            acc += 128'(ad * ad) * 128'(weight_mem[i]);
        end
        r.variance = div_sat(acc, wsum);
        r.status = dropped ? wmv_pkg::ST_OVERFLOW : wmv_pkg::ST_OK;
        return r;
    endfunction

    assign o_pending = stats_q.size();

    always @(posedge i_clk) begin
        t_stats exp_r;
        if (!i_rst_n) begin
            pair_count = 0;
            wsum = 0;
            xsum = 0;
            dropped = 0;
            min_wsum = wmv_pkg::MIN_WSUM_RESET;
            o_errors <= 0;
            o_results <= 0;
            stats_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) min_wsum = i_cfg.data;
            if (i_in.valid && i_in.ready) begin
                if (pair_count < DEPTH) begin
                    sample_mem[pair_count] = i_in.sample;
                    weight_mem[pair_count] = i_in.weight;
                    pair_count = pair_count + 1;
                    wsum += 64'(i_in.weight);
                    xsum += 64'(64'(i_in.sample) * $signed({48'd0, i_in.weight}));
                end else begin
                    dropped = 1;
                end
                if (i_in.last) begin
                    stats_q.push_back(finish_set());
                    pair_count = 0;
                    wsum = 0;
                    xsum = 0;
                    dropped = 0;
                end
            end
            if (i_out.valid && i_out.ready) begin
                o_results <= o_results + 1;
                if (stats_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected result beat status=%0d", i_out.status);
                end else begin
                    exp_r = stats_q.pop_front();
                    if (i_out.status !== exp_r.status || i_out.mean !== exp_r.mean
                            || i_out.variance !== exp_r.variance) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch exp st=%0d m=%h v=%h got st=%0d m=%h v=%h",
                                exp_r.status, exp_r.mean, exp_r.variance,
                                i_out.status, i_out.mean, i_out.variance);
                    end
                end
            end
        end
    end
endmodule

[dv/tb_weighted_mean_variance_core.sv]
`timescale 1ns / 1ps

module tb_weighted_mean_variance_core;
    logic i_clk;
    logic i_rst_n;
    int   errors, pending, results;
    int   n_items;

    wmv_in_if  in_if ();
    wmv_out_if out_if ();
    wmv_cfg_if cfg_if ();

    weighted_mean_variance_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_if.sink),
        .o_out(out_if.source), .i_cfg(cfg_if.sink)
    );

    wmv_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_if.sink), .i_out(out_if.sink),
        .i_cfg(cfg_if.sink), .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // output side stalls
    initial begin
        out_if.ready = 0;
        @(negedge i_clk);
        forever begin
            out_if.ready <= 1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
            repeat (gap_len()) begin
                out_if.ready <= 0;
                @(negedge i_clk);
            end
        end
    end

    // valid stays high after a beat until the next beat, a gap or a drain
    task automatic send_pair(logic [31:0] x, logic [15:0] w, logic lst, bit nogap);
        int n;
        if (!nogap) begin
            n = gap_len();
            if (n > 0) begin
                in_if.valid <= 0;
                repeat (n) @(negedge i_clk);
            end
        end
        in_if.valid <= 1;
        in_if.sample <= x;
        in_if.weight <= w;
        in_if.last <= lst;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        n_items++;
    endtask

    task automatic drain();
        in_if.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (1500) @(negedge i_clk);
    endtask

    task automatic write_min(logic [wmv_pkg::CFG_W-1:0] v);
        cfg_if.valid <= 1;
        cfg_if.data <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 0;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 65535)) << 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 16'hFFFF;
            1: return 16'd0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_set(int len);
        bit burst;
        burst = $urandom_range(0, 3) == 0;
        for (int i = 0; i < len; i++)
            send_pair(rand_sample(), rand_weight(), i == len - 1, burst);
    endtask

    initial begin
        n_items = 0;
        i_rst_n = 0;
        in_if.valid = 0;
        in_if.sample = 0;
        in_if.weight = 0;
        in_if.last = 0;
        cfg_if.valid = 0;
        cfg_if.data = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed
        send_pair(32'h7FFF_FFFF, 16'hFFFF, 0, 0);
        send_pair(32'h8000_0000, 16'hFFFF, 1, 0);
        send_pair(32'h8000_0000, 16'd1, 1, 0);
        send_pair(32'h7FFF_FFFF, 16'd3, 1, 0);
        send_pair(32'h0001_0000, 16'd0, 0, 0);
        send_pair(32'h0002_0000, 16'd0, 1, 0);
        send_pair(32'hFFFF_FFFF, 16'd2, 0, 0);
        send_pair(32'h0000_0001, 16'd1, 1, 0);
        drain();
        write_min(26'd200000);
        send_pair(32'h0001_0000, 16'hFFFF, 0, 0);
        send_pair(32'h0001_0000, 16'hFFFF, 1, 0);
        send_pair(32'h0001_0000, 16'hFFFF, 0, 0);
        send_pair(32'h0001_0000, 16'hFFFF, 0, 0);
        send_pair(32'h0001_0000, 16'hFFFF, 0, 0);
        send_pair(32'h0001_0000, 16'hFFFF, 1, 0);
        drain();
        write_min(26'h3FF_FFFF);
        send_pair(32'h1234_5678, 16'hFFFF, 1, 0);
        drain();
        write_min(26'd0);
        send_pair(32'h0, 16'd0, 1, 0);
        // store full: overflow with enough weight, then with too little
        for (int i = 0; i < wmv_pkg::MAX_ITEMS_DEF + 3; i++)
            send_pair($urandom, 16'($urandom), i == wmv_pkg::MAX_ITEMS_DEF + 2, 1);
        drain();
        write_min(26'h3FF_FFFF);
        for (int i = 0; i < wmv_pkg::MAX_ITEMS_DEF + 1; i++)
            send_pair($urandom, 16'd1, i == wmv_pkg::MAX_ITEMS_DEF, 1);
        drain();

        // random short sets, with a config change between phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_min(26'd1);
                1: write_min(wmv_pkg::CFG_W'($urandom_range(0, 300000)));
                2: write_min(26'd0);
                default: write_min(wmv_pkg::CFG_W'($urandom));
            endcase
            for (int s = 0; s < 15; s++) begin
                random_set($urandom_range(1, 8));
            end
            drain();
        end
        drain();
        $display("ran %0d pairs, %0d results checked, thresholds 0 to max, overflow sets",
            n_items, results);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

[weighted_mean_variance_core.f]
+incdir+sv
sv/wmv_pkg.sv
sv/wmv_in_if.sv
sv/wmv_out_if.sv
sv/wmv_cfg_if.sv
sv/wmv_ram.sv
sv/wmv_front.sv
sv/wmv_jobq.sv
sv/wmv_div.sv
sv/wmv_back.sv
sv/weighted_mean_variance_core.sv
dv/wmv_checker.sv
dv/tb_weighted_mean_variance_core.sv
